// ===== rtl/core/pptt_pkg.sv =====
// ----------------------------------------------------------------------------
// pptt_pkg
// types, codes and defaults shared by the phased periodic timer table
// ----------------------------------------------------------------------------
package pptt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int PHASE_SPAN_DEF = 256;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ALLOC  = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_CHPER  = 3'd4,
        CMD_FREE   = 3'd5,
        CMD_POLL   = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_ALLOC   = 3'd1,
        ST_NO_FREE     = 3'd2,
        ST_NOT_STOPPED = 3'd3,
        ST_BAD_PERIOD  = 3'd4,
        ST_BAD_PHASE   = 3'd5,
        ST_STOPPED     = 3'd6,
        ST_NOT_EXPIRED = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_WAITING = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DIV,
        FSM_EXEC,
        FSM_DONE
    } fsm_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic scan_start; // begin slot walk (tick / allocate)
        logic scan_step;  // advance slot walk
        logic div_start;  // begin remainder
        logic div_step;
        logic exec;       // apply single-slot command
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic alloc_hit;
        logic need_div;
        logic div_done;
    } stat_t;

endpackage

// ===== rtl/core/phased_periodic_timer_table.sv =====
// ----------------------------------------------------------------------------
// phased_periodic_timer_table
// table of phased periodic timers driven by a command stream
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)
// s_axis   in   cmd[2:0], timer_index[6:3], period[22:7], phase[38:23]; 40 bits
// m_axis   out  status_code[2:0], slot_index[6:3], fired_mask[22:7]; 24 bits
//
// tick and allocate walk the slots one a cycle
// start and change period may run the 16-step remainder unit
// other commands go through div, exec and done; one command is in work at a time
// rst_n clears the whole table at once, no clearing pass
// a held result does not stop intake once out tready is high
module phased_periodic_timer_table #(
    parameter int NUM_TIMERS = pptt_pkg::NUM_TIMERS_DEF,
    parameter int PHASE_SPAN = pptt_pkg::PHASE_SPAN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // cmd, timer_index, period, phase
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status_code, slot_index, fired_mask
);
    import pptt_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic [2:0]  status_code;
    logic [3:0]  slot_index;
    logic [15:0] fired_mask;

    pptt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tdata[2:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    pptt_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .PHASE_SPAN (PHASE_SPAN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_cmd      (s_axis_tdata[2:0]),
        .in_index    (s_axis_tdata[6:3]),
        .in_period   (s_axis_tdata[22:7]),
        .in_phase    (s_axis_tdata[38:23]),
        .ctrl        (ctrl),
        .stat        (stat),
        .status_code (status_code),
        .slot_index  (slot_index),
        .fired_mask  (fired_mask)
    );

    assign m_axis_tdata = {1'b0, fired_mask, slot_index, status_code};

endmodule

// ===== rtl/core/pptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pptt_ctrl
// command sequencer: slot walk, remainder iterations, result hand-off
// ----------------------------------------------------------------------------
module pptt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [2:0]     in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output pptt_pkg::ctrl_t ctrl,
    input  pptt_pkg::stat_t stat
);
    import pptt_pkg::*;

    fsm_t state_reg, state_next;
    logic valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                // a waiting result does not block intake once it is taken
                in_ready = !valid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    ctrl.load = 1'b1;
                    if (in_cmd == CMD_TICK || in_cmd == CMD_ALLOC)
                    begin
                        ctrl.scan_start = 1'b1;
                        state_next = FSM_SCAN;
                    end
                    else
                        state_next = FSM_DIV;
                end
            end
            FSM_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_last || stat.alloc_hit)
                    state_next = FSM_DONE;
            end
            FSM_DIV:
            begin
                if (!stat.need_div)
                    state_next = FSM_EXEC;
                else
                begin
                    ctrl.div_start = 1'b1;
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (stat.need_div && !stat.div_done)
                    ctrl.div_step = 1'b1;
                else
                begin
                    ctrl.exec = 1'b1;
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                valid_next = 1'b1;
                state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_DONE |=> out_valid)
        else $error("result not raised after done");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != FSM_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> !ctrl.exec)
        else $error("command applied twice");

endmodule

// ===== rtl/core/pptt_dp.sv =====
// ----------------------------------------------------------------------------
// pptt_dp
// timer table storage, slot walk, start checks and remainder unit
// ----------------------------------------------------------------------------
module pptt_dp #(
    parameter int NUM_TIMERS = pptt_pkg::NUM_TIMERS_DEF,
    parameter int PHASE_SPAN = pptt_pkg::PHASE_SPAN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      in_cmd,
    input  logic [3:0]      in_index,
    input  logic [15:0]     in_period,
    input  logic [15:0]     in_phase,
    input  pptt_pkg::ctrl_t ctrl,
    output pptt_pkg::stat_t stat,
    output logic [2:0]      status_code,
    output logic [3:0]      slot_index,
    output logic [15:0]     fired_mask
);
    import pptt_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SPW = $clog2(PHASE_SPAN + 1);
    localparam logic [16:0] SPAN17 = 17'(PHASE_SPAN);
    localparam logic [15:0] SPAN_M = 16'(PHASE_SPAN - 1); // mask when span is power of two
    localparam bit SPAN_POW2 = (PHASE_SPAN & (PHASE_SPAN - 1)) == 0;

    logic          used_reg [NUM_TIMERS];
    mode_t         mode_reg [NUM_TIMERS];
    logic [15:0]   per_reg  [NUM_TIMERS];
    logic [15:0]   ph_reg   [NUM_TIMERS];
    logic [15:0]   cnt_reg  [NUM_TIMERS];
    logic          pend_reg [NUM_TIMERS];
    logic [15:0]   phc_reg;

    logic [2:0]    cmd_reg;
    logic [3:0]    idx_reg;
    logic [15:0]   per_in_reg, ph_in_reg;
    logic [IW:0]   scan_reg;
    logic [2:0]    st_reg;
    logic [3:0]    slot_reg;
    logic [15:0]   mask_reg;

    // restoring remainder unit, one quotient bit per step
    logic [16:0]   rem_reg;
    logic [15:0]   quo_reg;
    logic [15:0]   dvs_reg;
    logic [4:0]    dcnt_reg;
    logic [1:0]    dsel_reg; // 0 none, 1 period mod span, 2 span mod period, 3 count mod period

    logic [IW-1:0] sidx;
    logic [IW-1:0] aidx;
    logic          addr_ok;
    logic [16:0]   rem_sh;
    logic [15:0]   phc_inc;
    logic          need_div;

    assign sidx    = scan_reg[IW-1:0];
    assign addr_ok = (32'(idx_reg) < NUM_TIMERS);
    assign aidx    = IW'(idx_reg);
    assign rem_sh  = {rem_reg[15:0], quo_reg[15]};
    assign phc_inc = (17'(phc_reg) + 17'd1 >= SPAN17) ? 16'd0 : phc_reg + 16'd1;

    always_comb
    begin
        need_div = 1'b0;
        if (addr_ok && used_reg[aidx])
        begin
            if (cmd_reg == CMD_START && mode_reg[aidx] == MODE_STOPPED && per_in_reg != 16'd0
                && !SPAN_POW2 && 17'(per_in_reg) != SPAN17)
                need_div = 1'b1;
            if (cmd_reg == CMD_CHPER && mode_reg[aidx] != MODE_STOPPED && per_in_reg != 16'd0)
                need_div = 1'b1;
        end
    end

    assign stat.scan_last = (32'(scan_reg) >= NUM_TIMERS - 1);
    assign stat.alloc_hit = (cmd_reg == CMD_ALLOC) && !used_reg[sidx];
    assign stat.need_div  = need_div;
    assign stat.div_done  = (dcnt_reg == 5'd16);

    assign status_code = st_reg;
    assign slot_index  = slot_reg;
    assign fired_mask  = mask_reg;

    // divisor check for start when span is a power of two
    function automatic logic pow2_ok(input logic [15:0] p);
        logic [16:0] p17;
        p17 = 17'(p);
        if (p17 > SPAN17)
            return (p & SPAN_M) == 16'd0;
        else
            return (p & (p - 16'd1)) == 16'd0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                used_reg[i] <= 1'b0;
                mode_reg[i] <= MODE_STOPPED;
                per_reg[i]  <= '0;
                ph_reg[i]   <= '0;
                cnt_reg[i]  <= '0;
                pend_reg[i] <= 1'b0;
            end
            phc_reg  <= '0;
            scan_reg <= '0;
            dcnt_reg <= '0;
            dsel_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                cmd_reg    <= in_cmd;
                idx_reg    <= in_index;
                per_in_reg <= in_period;
                ph_in_reg  <= in_phase;
                st_reg     <= (in_cmd == CMD_ALLOC) ? ST_NO_FREE : ST_OK;
                slot_reg   <= (in_cmd == CMD_TICK || in_cmd == CMD_ALLOC) ? 4'd0 : in_index;
                mask_reg   <= '0;
            end
            if (ctrl.scan_start)
            begin
                scan_reg <= '0;
                if (in_cmd == CMD_TICK)
                    phc_reg <= phc_inc;
            end
            if (ctrl.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (!used_reg[sidx])
                    begin
                        used_reg[sidx] <= 1'b1;
                        mode_reg[sidx] <= MODE_STOPPED;
                        st_reg         <= ST_OK;
                        slot_reg       <= 4'(scan_reg);
                    end
                end
                else if (used_reg[sidx])
                begin
                    if (mode_reg[sidx] == MODE_RUNNING)
                    begin
                        if (17'(cnt_reg[sidx]) + 17'd1 >= 17'(per_reg[sidx]))
                        begin
                            cnt_reg[sidx]  <= '0;
                            pend_reg[sidx] <= 1'b1;
                            if (32'(scan_reg) < 16)
                                mask_reg[4'(scan_reg)] <= 1'b1;
                        end
                        else
                            cnt_reg[sidx] <= cnt_reg[sidx] + 16'd1;
                    end
                    else if (mode_reg[sidx] != MODE_STOPPED && phc_reg == ph_reg[sidx])
                    begin
                        cnt_reg[sidx]  <= '0;
                        mode_reg[sidx] <= MODE_RUNNING;
                        pend_reg[sidx] <= 1'b1;
                        if (32'(scan_reg) < 16)
                            mask_reg[4'(scan_reg)] <= 1'b1;
                    end
                end
            end
            if (ctrl.div_start)
            begin
                dcnt_reg <= '0;
                rem_reg  <= '0;
                if (cmd_reg == CMD_CHPER)
                begin
                    dsel_reg <= 2'd3;
                    quo_reg  <= cnt_reg[aidx];
                    dvs_reg  <= per_in_reg;
                end
                else if (17'(per_in_reg) > SPAN17)
                begin
                    dsel_reg <= 2'd1;
                    quo_reg  <= per_in_reg;
                    dvs_reg  <= 16'(PHASE_SPAN);
                end
                else
                begin
                    dsel_reg <= 2'd2;
                    quo_reg  <= 16'(PHASE_SPAN);
                    dvs_reg  <= per_in_reg;
                end
            end
            if (ctrl.div_step)
            begin
                dcnt_reg <= dcnt_reg + 5'd1;
                quo_reg  <= {quo_reg[14:0], 1'b0};
                if (rem_sh >= 17'(dvs_reg))
                    rem_reg <= rem_sh - 17'(dvs_reg);
                else
                    rem_reg <= rem_sh;
            end
            if (ctrl.exec)
            begin
                if (cmd_reg == CMD_NONE)
                    st_reg <= ST_OK;
                else if (!addr_ok || !used_reg[aidx])
                    st_reg <= ST_NOT_ALLOC;
                else
                begin
                    unique case (cmd_reg)
                        CMD_START:
                        begin
                            if (mode_reg[aidx] != MODE_STOPPED)
                                st_reg <= ST_NOT_STOPPED;
                            else if (per_in_reg == 16'd0
                                || (SPAN_POW2 && !pow2_ok(per_in_reg))
                                || (need_div && rem_reg != 17'd0))
                                st_reg <= ST_BAD_PERIOD;
                            else if (17'(ph_in_reg) >= SPAN17)
                                st_reg <= ST_BAD_PHASE;
                            else
                            begin
                                per_reg[aidx]  <= per_in_reg;
                                ph_reg[aidx]   <= ph_in_reg;
                                cnt_reg[aidx]  <= '0;
                                mode_reg[aidx] <= MODE_WAITING;
                            end
                        end
                        CMD_STOP: mode_reg[aidx] <= MODE_STOPPED;
                        CMD_CHPER:
                        begin
                            if (mode_reg[aidx] == MODE_STOPPED)
                                st_reg <= ST_STOPPED;
                            else if (per_in_reg == 16'd0)
                                st_reg <= ST_BAD_PERIOD;
                            else
                            begin
                                per_reg[aidx] <= per_in_reg;
                                cnt_reg[aidx] <= rem_reg[15:0];
                            end
                        end
                        CMD_FREE:
                        begin
                            mode_reg[aidx] <= MODE_STOPPED;
                            used_reg[aidx] <= 1'b0;
                        end
                        CMD_POLL:
                        begin
                            if (pend_reg[aidx])
                            begin
                                pend_reg[aidx] <= 1'b0;
                                cnt_reg[aidx]  <= '0;
                            end
                            else
                                st_reg <= ST_NOT_EXPIRED;
                        end
                        default: st_reg <= ST_OK;
                    endcase
                end
                dsel_reg <= '0;
            end
        end
    end

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> dcnt_reg < 5'd16)
        else $error("remainder ran past its width");
    a_div_sel: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_step |-> dsel_reg != 2'd0)
        else $error("remainder stepped without an operand");
    a_phase_span: assert property (@(posedge clk) disable iff (!rst_n)
        SPW > 0 |-> 17'(phc_reg) < SPAN17)
        else $error("phase counter out of span");

endmodule
